@@ sv/swm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the spiral wipe mask generator
// Grid size, field widths, register indexes and the structs that pass
// configuration and results between the modules.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int GRID_SIZE = 16;
  localparam int CELL_W    = $clog2(GRID_SIZE);
  localparam int SUB_W     = 8;
  localparam int BLK_W     = 9;
  localparam int COORD_W   = 12;
  localparam int MASK_W    = 8;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = CELL_W + BLK_W;

  localparam logic [CELL_W-1:0] GRID_LAST = CELL_W'(GRID_SIZE - 1);

  localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd0;
  localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CORNER       = 2'd2;
  localparam logic [1:0] REG_TRANSPOSE    = 2'd3;

  typedef struct packed {
    logic [BLK_W-1:0] bw;
    logic [BLK_W-1:0] bh;
    logic [SUB_W-1:0] bw_m1;
    logic [SUB_W-1:0] bh_m1;
    logic [1:0]       corner;
    logic             transpose;
  } cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0]  mask_value;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic               end_of_row;
    logic               end_of_frame;
  } result_t;

endpackage
`default_nettype wire

@@ sv/spiral_wipe_mask_generator.sv @@
`default_nettype none
// A result item is registered in the result stage when its tick item is accepted.
// Throughput: one item per clock unless a stall holds the flow; the scan
// logic and the spiral lookup are combinational up to the result register.
// A two-slot result stage lets a tick be taken while a result waits.
// Reset clears the scan to the top-left pixel, empties the result stage and
// sets block width and height to 1, corner to 0 and transpose to 0.
// ----------------------------------------------------------------------------
// spiral_wipe_mask_generator: spiral wipe mask pixel stream
// Produces one mask pixel per tick in raster order over a 16 by 16 grid of
// cells, each pixel valued by its cell's position along an inward spiral.
// ----------------------------------------------------------------------------
module spiral_wipe_mask_generator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [swm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [swm_pkg::DATA_W-1:0]  pwdata,
  output logic      [swm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        tick_valid,
  output logic                             tick_stall,
  input  wire logic                        restart,
  output logic                             mask_valid,
  input  wire logic                        mask_stall,
  output logic      [swm_pkg::MASK_W-1:0]  mask_value,
  output logic      [swm_pkg::COORD_W-1:0] pixel_col,
  output logic      [swm_pkg::COORD_W-1:0] pixel_row,
  output logic                             end_of_row,
  output logic                             end_of_frame
);

  swm_pkg::cfg_t    cfg;
  swm_pkg::result_t scan_result;
  swm_pkg::result_t out_data;
  logic             advance;

  assign advance = tick_valid & ~tick_stall;

  swm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swm_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .restart (restart),
    .result  (scan_result)
  );

  swm_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick_valid),
    .in_stall  (tick_stall),
    .in_data   (scan_result),
    .out_valid (mask_valid),
    .out_stall (mask_stall),
    .out_data  (out_data)
  );

  assign mask_value   = out_data.mask_value;
  assign pixel_col    = out_data.pixel_col;
  assign pixel_row    = out_data.pixel_row;
  assign end_of_row   = out_data.end_of_row;
  assign end_of_frame = out_data.end_of_frame;

endmodule
`default_nettype wire

@@ sv/swm_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cfg: configuration registers
// Holds the block size, corner mirror and transpose registers behind the
// bus port and presents their clamped forms to the scan logic.
// ----------------------------------------------------------------------------
module swm_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [swm_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [swm_pkg::DATA_W-1:0]  pwdata,
  output logic      [swm_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output swm_pkg::cfg_t                    cfg
);

  logic [swm_pkg::BLK_W-1:0] block_width;
  logic [swm_pkg::BLK_W-1:0] block_height;
  logic [1:0]                corner;
  logic                      transpose;
  logic                      wr;
  logic [1:0]                idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_width  <= swm_pkg::BLK_W'(1);
      block_height <= swm_pkg::BLK_W'(1);
      corner       <= 2'd0;
      transpose    <= 1'b0;
    end else if (wr) begin
      case (idx)
        swm_pkg::REG_BLOCK_WIDTH:  block_width  <= pwdata[swm_pkg::BLK_W-1:0];
        swm_pkg::REG_BLOCK_HEIGHT: block_height <= pwdata[swm_pkg::BLK_W-1:0];
        swm_pkg::REG_CORNER:       corner       <= pwdata[1:0];
        swm_pkg::REG_TRANSPOSE:    transpose    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      swm_pkg::REG_BLOCK_WIDTH:  prdata = swm_pkg::DATA_W'(block_width);
      swm_pkg::REG_BLOCK_HEIGHT: prdata = swm_pkg::DATA_W'(block_height);
      swm_pkg::REG_CORNER:       prdata = swm_pkg::DATA_W'(corner);
      swm_pkg::REG_TRANSPOSE:    prdata = swm_pkg::DATA_W'(transpose);
      default:                   prdata = '0;
    endcase
  end

  // A size of zero acts as one, anything above 256 acts as 256.
  always_comb begin
    if (block_width == '0) begin
      cfg.bw_m1 = '0;
    end else if (block_width[swm_pkg::BLK_W-1]) begin
      cfg.bw_m1 = '1;
    end else begin
      cfg.bw_m1 = block_width[swm_pkg::SUB_W-1:0] - swm_pkg::SUB_W'(1);
    end
    if (block_height == '0) begin
      cfg.bh_m1 = '0;
    end else if (block_height[swm_pkg::BLK_W-1]) begin
      cfg.bh_m1 = '1;
    end else begin
      cfg.bh_m1 = block_height[swm_pkg::SUB_W-1:0] - swm_pkg::SUB_W'(1);
    end
    cfg.bw        = swm_pkg::BLK_W'(cfg.bw_m1) + swm_pkg::BLK_W'(1);
    cfg.bh        = swm_pkg::BLK_W'(cfg.bh_m1) + swm_pkg::BLK_W'(1);
    cfg.corner    = corner;
    cfg.transpose = transpose;
  end

endmodule
`default_nettype wire

@@ sv/swm_spiral.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swm_spiral: spiral order lookup
// Gives the position of a grid cell along the clockwise inward spiral that
// starts in the top-left cell and first moves right.
// ----------------------------------------------------------------------------
module swm_spiral (
  input  wire logic [swm_pkg::CELL_W-1:0] row,
  input  wire logic [swm_pkg::CELL_W-1:0] col,
  output logic      [swm_pkg::MASK_W-1:0] order
);

  localparam int SW = 10;

  logic [swm_pkg::CELL_W-1:0] row_inv;
  logic [swm_pkg::CELL_W-1:0] col_inv;
  logic [swm_pkg::CELL_W-1:0] k;
  logic [swm_pkg::CELL_W-1:0] k_a;
  logic [swm_pkg::CELL_W-1:0] k_b;
  logic [swm_pkg::CELL_W-1:0] far;
  logic [SW-1:0]              base;
  logic [SW-1:0]              side;
  logic [SW-1:0]              sum;

  always_comb begin
    row_inv = swm_pkg::GRID_LAST - row;
    col_inv = swm_pkg::GRID_LAST - col;
    k_a     = (row < col) ? row : col;
    k_b     = (row_inv < col_inv) ? row_inv : col_inv;
    k       = (k_a < k_b) ? k_a : k_b;
    far     = swm_pkg::GRID_LAST - k;
    base    = SW'(4) * SW'(k) * (SW'(swm_pkg::GRID_SIZE) - SW'(k));
    side    = SW'(swm_pkg::GRID_SIZE) - SW'(2) * SW'(k) - SW'(1);
    if (side == '0) begin
      sum = base;
    end else if (row == k) begin
      sum = base + SW'(col - k);
    end else if (col == far) begin
      sum = base + side + SW'(row - k);
    end else if (row == far) begin
      sum = base + SW'(2) * side + SW'(far - col);
    end else begin
      sum = base + SW'(3) * side + SW'(far - row);
    end
    order = sum[swm_pkg::MASK_W-1:0];
  end

endmodule
`default_nettype wire

@@ sv/swm_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swm_scan: raster scan counters and per-pixel result
// Walks the sub-cell and cell positions in raster order and forms the mask
// value, pixel coordinates and end flags of the current pixel.
// ----------------------------------------------------------------------------
module swm_scan (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire swm_pkg::cfg_t cfg,
  input  wire logic          advance,
  input  wire logic          restart,
  output swm_pkg::result_t   result
);

  localparam int PW = swm_pkg::PROD_W;

  logic [swm_pkg::SUB_W-1:0]  sub_col;
  logic [swm_pkg::CELL_W-1:0] cell_col;
  logic [swm_pkg::SUB_W-1:0]  sub_row;
  logic [swm_pkg::CELL_W-1:0] cell_row;
  logic [swm_pkg::SUB_W-1:0]  sub_col_next;
  logic [swm_pkg::CELL_W-1:0] cell_col_next;
  logic [swm_pkg::SUB_W-1:0]  sub_row_next;
  logic [swm_pkg::CELL_W-1:0] cell_row_next;

  logic [swm_pkg::SUB_W-1:0]  sc;
  logic [swm_pkg::CELL_W-1:0] cc;
  logic [swm_pkg::SUB_W-1:0]  sr;
  logic [swm_pkg::CELL_W-1:0] cr;
  logic                       sub_col_last;
  logic                       cell_col_last;
  logic                       sub_row_last;
  logic                       cell_row_last;
  logic [swm_pkg::CELL_W-1:0] xc;
  logic [swm_pkg::CELL_W-1:0] yc;
  logic [swm_pkg::CELL_W-1:0] look_row;
  logic [swm_pkg::CELL_W-1:0] look_col;
  logic [swm_pkg::MASK_W-1:0] order;
  logic [PW-1:0]              col_sum;
  logic [PW-1:0]              row_sum;

  always_comb begin
    sc = restart ? '0 : sub_col;
    cc = restart ? '0 : cell_col;
    sr = restart ? '0 : sub_row;
    cr = restart ? '0 : cell_row;
    sub_col_last  = sc >= cfg.bw_m1;
    cell_col_last = cc >= swm_pkg::GRID_LAST;
    sub_row_last  = sr >= cfg.bh_m1;
    cell_row_last = cr >= swm_pkg::GRID_LAST;
    xc = cfg.corner[0] ? swm_pkg::GRID_LAST - cc : cc;
    yc = cfg.corner[1] ? swm_pkg::GRID_LAST - cr : cr;
    look_row = cfg.transpose ? xc : yc;
    look_col = cfg.transpose ? yc : xc;
  end

  swm_spiral u_spiral (
    .row   (look_row),
    .col   (look_col),
    .order (order)
  );

  always_comb begin
    col_sum = PW'(cc) * PW'(cfg.bw) + PW'(sc);
    row_sum = PW'(cr) * PW'(cfg.bh) + PW'(sr);
    result.mask_value   = order;
    result.pixel_col    = col_sum[swm_pkg::COORD_W-1:0];
    result.pixel_row    = row_sum[swm_pkg::COORD_W-1:0];
    result.end_of_row   = sub_col_last & cell_col_last;
    result.end_of_frame = sub_col_last & cell_col_last & sub_row_last & cell_row_last;
  end

  always_comb begin
    sub_col_next  = sc;
    cell_col_next = cc;
    sub_row_next  = sr;
    cell_row_next = cr;
    if (sub_col_last) begin
      sub_col_next = '0;
      if (cell_col_last) begin
        cell_col_next = '0;
        if (sub_row_last) begin
          sub_row_next  = '0;
          cell_row_next = cell_row_last ? '0 : cr + swm_pkg::CELL_W'(1);
        end else begin
          sub_row_next = sr + swm_pkg::SUB_W'(1);
        end
      end else begin
        cell_col_next = cc + swm_pkg::CELL_W'(1);
      end
    end else begin
      sub_col_next = sc + swm_pkg::SUB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_col  <= '0;
      cell_col <= '0;
      sub_row  <= '0;
      cell_row <= '0;
    end else if (advance) begin
      sub_col  <= sub_col_next;
      cell_col <= cell_col_next;
      sub_row  <= sub_row_next;
      cell_row <= cell_row_next;
    end
  end

endmodule
`default_nettype wire

@@ sv/swm_skid.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swm_skid: result register with skid stage
// Registers each result item and keeps a second slot, so that a new item
// is taken in the cycle in which a finished one still waits downstream.
// ----------------------------------------------------------------------------
module swm_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire swm_pkg::result_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output swm_pkg::result_t      out_data
);

  logic             skid_valid;
  swm_pkg::result_t skid_data;
  logic             take;
  logic             acc;

  assign in_stall = skid_valid;
  assign take     = out_valid & ~out_stall;
  assign acc      = in_valid & ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (acc) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (acc) begin
      if (!out_valid || take) begin
        out_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds an item while the result register is empty");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result item was dropped");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_stall) |=> (!skid_valid && out_valid))
    else $error("skid slot did not move into the result register");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    (!skid_valid && in_valid && out_valid && out_stall) |=> skid_valid)
    else $error("item taken under stall did not land in the skid slot");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for the spiral wipe mask generator
// Sends tick items with random gaps and checks every mask item against a
// predictor of the scan counters and the spiral lookup. Covers the register
// extremes, corner mirrors, transpose, random frames, full for small blocks.
// ----------------------------------------------------------------------------
module testbench;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [swm_pkg::ADDR_W-1:0]   paddr        = '0;
  logic [swm_pkg::DATA_W-1:0]   pwdata       = '0;
  logic [swm_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         tick_valid   = 1'b0;
  logic                         tick_stall;
  logic                         restart      = 1'b0;
  logic                         mask_valid;
  logic                         mask_stall   = 1'b0;
  logic [swm_pkg::MASK_W-1:0]   mask_value;
  logic [swm_pkg::COORD_W-1:0]  pixel_col;
  logic [swm_pkg::COORD_W-1:0]  pixel_row;
  logic                         end_of_row;
  logic                         end_of_frame;

  logic [swm_pkg::BLK_W-1:0]    cell_width_reg  = 9'd1;
  logic [swm_pkg::BLK_W-1:0]    cell_height_reg = 9'd1;
  logic [1:0]                   corner_reg      = 2'd0;
  logic                         transpose_reg   = 1'b0;
  int                           scan_sub_x      = 0;
  int                           scan_cell_x     = 0;
  int                           scan_sub_y      = 0;
  int                           scan_cell_y     = 0;

  swm_pkg::result_t             pending_pixels[$];
  swm_pkg::result_t             oldest_pixel;
  int                           fail_count  = 0;
  int                           stall_left  = 0;
  int                           stall_len   = 0;
  logic                         no_idle     = 1'b0;

  spiral_wipe_mask_generator uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .restart      (restart),
    .mask_valid   (mask_valid),
    .mask_stall   (mask_stall),
    .mask_value   (mask_value),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic int usable_size(input logic [swm_pkg::BLK_W-1:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic int min2(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [swm_pkg::MASK_W-1:0] ring_position(input int r, input int c);
    int last, k, side, start;
    last  = swm_pkg::GRID_SIZE - 1;
    k     = min2(min2(r, c), min2(last - r, last - c));
    side  = swm_pkg::GRID_SIZE - 2 * k;
    start = 4 * k * (swm_pkg::GRID_SIZE - k);
    if (side <= 1) return swm_pkg::MASK_W'(start);
    if (r == k) return swm_pkg::MASK_W'(start + c - k);
    if (c == last - k) return swm_pkg::MASK_W'(start + (side - 1) + (r - k));
    if (r == last - k) return swm_pkg::MASK_W'(start + 2 * (side - 1) + (last - k - c));
    return swm_pkg::MASK_W'(start + 3 * (side - 1) + (last - k - r));
  endfunction

  function automatic swm_pkg::result_t next_mask_pixel(input logic rs);
    swm_pkg::result_t px;
    int               bw, bh, last, gx, gy;
    logic             row_done, col_done;
    bw   = usable_size(cell_width_reg);
    bh   = usable_size(cell_height_reg);
    last = swm_pkg::GRID_SIZE - 1;
    if (rs) begin
      scan_sub_x  = 0;
      scan_cell_x = 0;
      scan_sub_y  = 0;
      scan_cell_y = 0;
    end
    gx = min2(scan_cell_x, last);
    gy = min2(scan_cell_y, last);
    if (corner_reg[0]) gx = last - gx;
    if (corner_reg[1]) gy = last - gy;
    px.mask_value   = transpose_reg ? ring_position(gx, gy) : ring_position(gy, gx);
    px.pixel_col    = swm_pkg::COORD_W'(scan_cell_x * bw + scan_sub_x);
    px.pixel_row    = swm_pkg::COORD_W'(scan_cell_y * bh + scan_sub_y);
    row_done        = (scan_sub_x >= bw - 1) && (scan_cell_x >= last);
    col_done        = (scan_sub_y >= bh - 1) && (scan_cell_y >= last);
    px.end_of_row   = row_done;
    px.end_of_frame = row_done && col_done;
    if (scan_sub_x >= bw - 1) begin
      scan_sub_x = 0;
      if (scan_cell_x >= last) begin
        scan_cell_x = 0;
        if (scan_sub_y >= bh - 1) begin
          scan_sub_y  = 0;
          scan_cell_y = (scan_cell_y >= last) ? 0 : ((scan_cell_y + 1) & 15);
        end else begin
          scan_sub_y = (scan_sub_y + 1) & 255;
        end
      end else begin
        scan_cell_x = (scan_cell_x + 1) & 15;
      end
    end else begin
      scan_sub_x = (scan_sub_x + 1) & 255;
    end
    return px;
  endfunction

  task automatic write_reg(input logic [1:0] index, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= swm_pkg::ADDR_W'({index, 2'b00});
    pwdata  <= swm_pkg::DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      swm_pkg::REG_BLOCK_WIDTH:  cell_width_reg  = value[swm_pkg::BLK_W-1:0];
      swm_pkg::REG_BLOCK_HEIGHT: cell_height_reg = value[swm_pkg::BLK_W-1:0];
      swm_pkg::REG_CORNER:       corner_reg      = value[1:0];
      swm_pkg::REG_TRANSPOSE:    transpose_reg   = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_tick(input logic rs);
    int gap;
    gap = idle_len();
    if (gap != 0) begin
      tick_valid <= 1'b0;
      restart    <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    restart    <= rs;
    do @(posedge clk); while (tick_stall);
    pending_pixels.push_back(next_mask_pixel(rs));
  endtask

  task automatic wait_idle();
    tick_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && mask_valid && !mask_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("Unexpected mask item: value %0d col %0d row %0d",
               mask_value, pixel_col, pixel_row);
        fail_count++;
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        compare_field("mask_value", oldest_pixel.mask_value, mask_value);
        compare_field("pixel_col", oldest_pixel.pixel_col, pixel_col);
        compare_field("pixel_row", oldest_pixel.pixel_row, pixel_row);
        compare_field("end_of_row", oldest_pixel.end_of_row, end_of_row);
        compare_field("end_of_frame", oldest_pixel.end_of_frame, end_of_frame);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_len = idle_len();
      mask_stall <= (stall_len != 0);
      stall_left <= (stall_len != 0) ? stall_len - 1 : 0;
    end
  end

  task automatic test_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_size_limits();
    wait_idle();
    write_reg(swm_pkg::REG_BLOCK_WIDTH, 0);
    write_reg(swm_pkg::REG_BLOCK_HEIGHT, 0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    wait_idle();
    write_reg(swm_pkg::REG_BLOCK_WIDTH, 511);
    write_reg(swm_pkg::REG_BLOCK_HEIGHT, 511);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
  endtask

  // The column counter sits beyond the new cell width and must wrap.
  task automatic test_shrink_mid_cell();
    wait_idle();
    write_reg(swm_pkg::REG_BLOCK_WIDTH, 2);
    repeat (3) send_tick(1'b0);
  endtask

  task automatic test_mirror_transpose();
    wait_idle();
    write_reg(swm_pkg::REG_BLOCK_WIDTH, 1);
    write_reg(swm_pkg::REG_BLOCK_HEIGHT, 1);
    write_reg(swm_pkg::REG_TRANSPOSE, 1);
    for (int c = 0; c < 4; c++) begin
      wait_idle();
      write_reg(swm_pkg::REG_CORNER, c);
      send_tick(1'b1);
      send_tick(1'b0);
    end
  endtask

  function automatic int unsigned pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 1;
    if (r < 65) return 2;
    if (r < 75) return $urandom_range(3, 8);
    if (r < 82) return 0;
    if (r < 88) return 256;
    if (r < 93) return $urandom_range(257, 511);
    return $urandom_range(1, 511);
  endfunction

  task automatic test_random_frames();
    int sent, count, cells;
    sent = 0;
    while (sent < 1350) begin
      wait_idle();
      write_reg(swm_pkg::REG_BLOCK_WIDTH, pick_size());
      write_reg(swm_pkg::REG_BLOCK_HEIGHT, pick_size());
      write_reg(swm_pkg::REG_CORNER, $urandom_range(0, 3));
      write_reg(swm_pkg::REG_TRANSPOSE, $urandom_range(0, 1));
      no_idle = ($urandom_range(0, 4) == 0);
      cells = usable_size(cell_width_reg) * usable_size(cell_height_reg);
      count = (cells <= 2) ? cells * 256 + $urandom_range(0, 40) : $urandom_range(40, 150);
      for (int i = 0; i < count; i++) begin
        if (i == 0) send_tick(1'($urandom_range(0, 1)));
        else send_tick($urandom_range(0, 199) == 0);
      end
      sent += count;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_size_limits();
    test_shrink_mid_cell();
    test_mirror_transpose();
    test_random_frames();
    wait_idle();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/swm_pkg.sv
sv/swm_cfg.sv
sv/swm_spiral.sv
sv/swm_scan.sv
sv/swm_skid.sv
sv/spiral_wipe_mask_generator.sv
tb/testbench.sv
